>>> src/cbq_pkg.sv
// Shared types, constants and coefficient table for the cascaded biquad bandpass.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cbq_pkg;

    // default datapath sizes
    localparam int SIGNAL_WIDTH_DEF   = 40;
    localparam int COEF_FRAC_BITS_DEF = 28;

    // fixed sample formats
    localparam int SAMPLE_W    = 16;
    localparam int SAMPLE_FRAC = 15;
    // 32767 = 2^15 - 1, applied as a shift and a subtract
    localparam int OUT_SHIFT   = 15;

    // filter structure
    localparam int NUM_STAGES = 3;
    localparam int NUM_TAPS   = 5;
    localparam int TAP_W      = 3;
    localparam int STAGE_W    = 2;
    localparam int STEP_W     = 4;

    // tap codes: current input, two past inputs, two past outputs
    localparam logic [TAP_W-1:0] TAP_X0 = 3'd0;
    localparam logic [TAP_W-1:0] TAP_X1 = 3'd1;
    localparam logic [TAP_W-1:0] TAP_X2 = 3'd2;
    localparam logic [TAP_W-1:0] TAP_Y1 = 3'd3;
    localparam logic [TAP_W-1:0] TAP_Y2 = 3'd4;

    // two partial products per tap
    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(2 * NUM_TAPS - 1);
    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(NUM_STAGES - 1);

    // b0, b1, b2, -a1, -a2 per stage at 30 fraction bits
    localparam longint COEF_Q30 [NUM_STAGES][NUM_TAPS] = '{
        '{ 64'sd316700452,  64'sd0,          -64'sd316700452,
           64'sd659112381,  64'sd61373652 },
        '{ 64'sd1073741824, 64'sd2147483648,  64'sd1073741824,
          -64'sd1067956826, -64'sd649665558 },
        '{ 64'sd1073741824, -64'sd2147483648, 64'sd1073741824,
           64'sd1977250901, -64'sd945424200 }
    };

    // coefficient reduced to frac fraction bits, half rounds up
    function automatic longint coef_at(logic [STAGE_W-1:0] st, logic [TAP_W-1:0] k,
                                       int frac);
        longint c;
        c = 0;
        if (st < STAGE_W'(NUM_STAGES) && k < TAP_W'(NUM_TAPS))
        begin
            c = COEF_Q30[st][k];
        end
        return (2 * c + (64'sd1 <<< (30 - frac))) >>> (31 - frac);
    endfunction

    // commands from the controller to the datapath
    typedef struct packed {
        logic               load;
        logic               issue;
        logic [TAP_W-1:0]   tap;
        logic               half;
        logic [STAGE_W-1:0] stage;
        logic               fin;
        logic               clamp;
        logic               out_load;
        logic               clear_hist;
    } cbq_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic last_held;
    } cbq_stat_t;

endpackage

`default_nettype wire

>>> src/cbq_ctrl.sv
// Sequencer for the biquad cascade: steps taps, stages, output clamp and hand-off.
// Depends on cbq_pkg for the command and status structs and sequence limits.
`timescale 1ns / 1ps
`default_nettype none

module cbq_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output cbq_pkg::cbq_cmd_t      cmd,
    input  wire cbq_pkg::cbq_stat_t stat
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MAC   = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_FIN   = 6'b001000,
        ST_CLAMP = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [cbq_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [cbq_pkg::STAGE_W-1:0]     stage_reg, stage_next;
    logic                            out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        stage_next     = stage_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.stage      = stage_reg;
        cmd.tap        = step_reg[cbq_pkg::STEP_W-1:1];
        cmd.half       = step_reg[0];
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    stage_next = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.issue = 1'b1;
                if (step_reg == cbq_pkg::LAST_STEP)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.fin = 1'b1;
                if (stage_reg == cbq_pkg::LAST_STAGE)
                begin
                    state_next = ST_CLAMP;
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.clear_hist = stat.last_held;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            stage_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> src/cbq_datapath.sv
// Datapath: filter history, shared multiplier, accumulator, stage rounding and output scaling.
// Depends on cbq_pkg for the coefficient table, tap codes and command struct.
`timescale 1ns / 1ps
`default_nettype none

module cbq_datapath
#(
    parameter int SIGNAL_WIDTH   = cbq_pkg::SIGNAL_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = cbq_pkg::COEF_FRAC_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cbq_pkg::cbq_cmd_t              cmd,
    output cbq_pkg::cbq_stat_t                  stat,
    input  wire logic signed [cbq_pkg::SAMPLE_W-1:0] sample_in,
    input  wire logic                           last_of_clip,
    output logic signed [cbq_pkg::SAMPLE_W-1:0] sample_out
);

    localparam int W       = SIGNAL_WIDTH;
    localparam int F       = COEF_FRAC_BITS;
    localparam int COEF_W  = F + 3;
    localparam int LO_W    = W / 2;
    localparam int HI_W    = W - LO_W;
    localparam int MUL_A_W = HI_W + 1;
    localparam int PROD_W  = MUL_A_W + COEF_W;
    localparam int ACC_W   = W + COEF_W + 2;
    localparam int SH_W    = ACC_W - F;
    localparam int CL_W    = F + 2;
    localparam int P_W     = CL_W + cbq_pkg::OUT_SHIFT;
    localparam int IN_SHIFT = F - cbq_pkg::SAMPLE_FRAC;
    localparam int NS      = cbq_pkg::NUM_STAGES;

    localparam logic signed [ACC_W-1:0] ROUND_INIT = ACC_W'(1) << (F - 1);
    localparam logic signed [SH_W-1:0]  SAT_MAX    = SH_W'({(W - 1){1'b1}});
    localparam logic signed [SH_W-1:0]  SAT_MIN    = ~SAT_MAX;
    localparam logic signed [W-1:0]     ONE_W      = W'(1) << F;
    localparam logic signed [W-1:0]     NEG_ONE_W  = -ONE_W;
    localparam logic signed [P_W-1:0]   TRUNC_BIAS = (P_W'(1) << F) - P_W'(1);

    // history and working registers
    logic signed [W-1:0]      x1_reg [NS];
    logic signed [W-1:0]      x2_reg [NS];
    logic signed [W-1:0]      y1_reg [NS];
    logic signed [W-1:0]      y2_reg [NS];
    logic                     last_reg;
    logic signed [W-1:0]      cur_x_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic                     prod_half_reg;
    logic signed [P_W-1:0]    p_reg;
    logic signed [cbq_pkg::SAMPLE_W-1:0] out_data_reg;

    logic signed [W-1:0]       hx1, hx2, hy1, hy2;
    logic signed [W-1:0]       operand;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [COEF_W-1:0]  coef;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   addend;
    logic signed [SH_W-1:0]    shifted;
    logic signed [W-1:0]       y_sat;
    logic signed [CL_W-1:0]    x_clamp;
    logic signed [P_W-1:0]     p_scaled;
    logic signed [P_W-1:0]     p_biased;
    logic signed [P_W-1:0]     p_trunc;
    logic signed [W-1:0]       x_in;

    // history of the active stage
    always_comb
    begin
        hx1 = '0;
        hx2 = '0;
        hy1 = '0;
        hy2 = '0;
        for (int s = 0; s < NS; s++)
        begin
            if (cmd.stage == cbq_pkg::STAGE_W'(s))
            begin
                hx1 = x1_reg[s];
                hx2 = x2_reg[s];
                hy1 = y1_reg[s];
                hy2 = y2_reg[s];
            end
        end
    end

    // operand select and split into low and high partial words
    always_comb
    begin
        case (cmd.tap)
            cbq_pkg::TAP_X0: operand = cur_x_reg;
            cbq_pkg::TAP_X1: operand = hx1;
            cbq_pkg::TAP_X2: operand = hx2;
            cbq_pkg::TAP_Y1: operand = hy1;
            cbq_pkg::TAP_Y2: operand = hy2;
            default:         operand = '0;
        endcase
        if (cmd.half)
        begin
            mul_a = {operand[W-1], operand[W-1:LO_W]};
        end
        else
        begin
            mul_a = {{(MUL_A_W - LO_W){1'b0}}, operand[LO_W-1:0]};
        end
        coef = COEF_W'(cbq_pkg::coef_at(cmd.stage, cmd.tap, F));
        prod = mul_a * coef;
    end

    // accumulate the registered partial product
    always_comb
    begin
        prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        addend   = prod_half_reg ? (prod_ext <<< LO_W) : prod_ext;
    end

    // stage result: drop fraction bits, saturate to the signal range
    always_comb
    begin
        shifted = SH_W'(acc_reg >>> F);
        if (shifted > SAT_MAX)
        begin
            y_sat = W'(SAT_MAX);
        end
        else if (shifted < SAT_MIN)
        begin
            y_sat = W'(SAT_MIN);
        end
        else
        begin
            y_sat = W'(shifted);
        end
    end

    // clamp to plus or minus one and scale by 32767
    always_comb
    begin
        if (cur_x_reg > ONE_W)
        begin
            x_clamp = CL_W'(ONE_W);
        end
        else if (cur_x_reg < NEG_ONE_W)
        begin
            x_clamp = CL_W'(NEG_ONE_W);
        end
        else
        begin
            x_clamp = CL_W'(cur_x_reg);
        end
        p_scaled = {x_clamp, {cbq_pkg::OUT_SHIFT{1'b0}}}
                 - {{cbq_pkg::OUT_SHIFT{x_clamp[CL_W-1]}}, x_clamp};
    end

    // truncation toward zero
    always_comb
    begin
        p_biased = p_reg + (p_reg[P_W-1] ? TRUNC_BIAS : P_W'(0));
        p_trunc  = p_biased >>> F;
    end

    assign x_in = {{(W - cbq_pkg::SAMPLE_W){sample_in[cbq_pkg::SAMPLE_W-1]}}, sample_in}
                  <<< IN_SHIFT;

    // filter history and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                x1_reg[s] <= '0;
                x2_reg[s] <= '0;
                y1_reg[s] <= '0;
                y2_reg[s] <= '0;
            end
            last_reg       <= 1'b0;
            prod_valid_reg <= 1'b0;
            prod_half_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= cmd.issue;
            prod_half_reg  <= cmd.half;
            if (cmd.load)
            begin
                last_reg <= last_of_clip;
            end
            if (cmd.fin)
            begin
                for (int s = 0; s < NS; s++)
                begin
                    if (cmd.stage == cbq_pkg::STAGE_W'(s))
                    begin
                        x2_reg[s] <= x1_reg[s];
                        x1_reg[s] <= cur_x_reg;
                        y2_reg[s] <= y1_reg[s];
                        y1_reg[s] <= y_sat;
                    end
                end
            end
            if (cmd.out_load && cmd.clear_hist)
            begin
                for (int s = 0; s < NS; s++)
                begin
                    x1_reg[s] <= '0;
                    x2_reg[s] <= '0;
                    y1_reg[s] <= '0;
                    y2_reg[s] <= '0;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            prod_reg <= prod;
        end
        if (cmd.load)
        begin
            cur_x_reg <= x_in;
            acc_reg   <= ROUND_INIT;
        end
        else if (cmd.fin)
        begin
            cur_x_reg <= y_sat;
            acc_reg   <= ROUND_INIT;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + addend;
        end
        if (cmd.clamp)
        begin
            p_reg <= p_scaled;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= p_trunc[cbq_pkg::SAMPLE_W-1:0];
        end
    end

    assign stat.last_held = last_reg;
    assign sample_out     = out_data_reg;

endmodule

`default_nettype wire

>>> src/cascaded_biquad_bandpass.sv
// Three-stage biquad bandpass, 300-2700 Hz at 8 kHz, one shared multiplier.
// One sample is in work at a time: in_stall stays high until its result is loaded
// into the output register. Each stage runs five taps as two partial products
// through the shared multiplier, plus drain and write-back.
// Reset (rst_n low, asynchronous) clears filter history and all handshake state.
// Depends on cbq_pkg, cbq_ctrl and cbq_datapath.
`timescale 1ns / 1ps
`default_nettype none

module cascaded_biquad_bandpass
#(
    parameter int SIGNAL_WIDTH   = cbq_pkg::SIGNAL_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = cbq_pkg::COEF_FRAC_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [cbq_pkg::SAMPLE_W-1:0] sample_in,
    input  wire logic                           last_of_clip,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [cbq_pkg::SAMPLE_W-1:0] sample_out
);

    cbq_pkg::cbq_cmd_t  cmd;
    cbq_pkg::cbq_stat_t stat;

    // sequencer
    cbq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // arithmetic and history
    cbq_datapath
    #(
        .SIGNAL_WIDTH   (SIGNAL_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .sample_in    (sample_in),
        .last_of_clip (last_of_clip),
        .sample_out   (sample_out)
    );

endmodule

`default_nettype wire

>>> src/cbq_checker.sv
// Port-level checks for the biquad bandpass, bound to the top level.
// Depends on cbq_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

module cbq_checker
(
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic signed [cbq_pkg::SAMPLE_W-1:0] sample_in,
    input wire logic                            last_of_clip,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic signed [cbq_pkg::SAMPLE_W-1:0] sample_out
);

    // a stalled input item keeps its payload
    a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> $stable(sample_in) && $stable(last_of_clip))
        else $error("input item changed while stalled");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sample_out))
        else $error("result changed while stalled");

    // output is symmetric saturated, never the most negative code
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_out != 16'sh8000)
        else $error("result outside plus or minus 32767");

    // one item at a time: input stalls right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled while an item is in work");

endmodule

bind cascaded_biquad_bandpass cbq_checker u_cbq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .last_of_clip (last_of_clip),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out)
);

`default_nettype wire
